/* design/spc_pkg.sv */
// ----------------------------------------------------------------------------
// Simple polygon check package
// Shared types and fixed constants of the polygon self-intersection checker.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

    localparam int IN_COORD_BITS = 16;
    localparam int MIN_CHECK_VERTICES = 5;
    localparam int MUL_STEPS = 8;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_RD_D,
        ST_RD_NEXT,
        ST_CAP_D,
        ST_MUL,
        ST_EVAL,
        ST_RESULT
    } t_state;

    typedef enum logic [1:0] {
        SIDE_ZERO,
        SIDE_POS,
        SIDE_NEG
    } t_side;

    typedef struct packed {
        logic       mul_en;
        logic [2:0] mul_step;
        logic       res_en;
        logic [2:0] res_step;
    } t_side_ctrl;

endpackage

`default_nettype wire

/* design/spc_if.sv */
// ----------------------------------------------------------------------------
// Simple polygon check channels
// Valid/ready channels for vertex input and check results.
// ----------------------------------------------------------------------------
`default_nettype none

interface spc_vertex_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [spc_pkg::IN_COORD_BITS-1:0]  vertex_x;
    logic signed [spc_pkg::IN_COORD_BITS-1:0]  vertex_y;
    logic                                      last_vertex;

    modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
    modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface spc_result_if;
    logic valid;
    logic ready;
    logic is_simple;
    logic overflow;

    modport source (output valid, is_simple, overflow, input ready);
    modport sink   (input valid, is_simple, overflow, output ready);
endinterface

`default_nettype wire

/* design/spc_vertex_mem.sv */
// ----------------------------------------------------------------------------
// Vertex store
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_vertex_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* design/spc_side_unit.sv */
// ----------------------------------------------------------------------------
// Side unit
// One shared multiplier that works out the four point-versus-edge sides of
// an edge pair over a sequence of steps.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_side_unit #(
    parameter int CB = 16
) (
    input  wire logic                    i_clk,
    input  wire spc_pkg::t_side_ctrl     i_ctrl,
    input  wire logic signed [CB-1:0]    i_ax,
    input  wire logic signed [CB-1:0]    i_ay,
    input  wire logic signed [CB-1:0]    i_bx,
    input  wire logic signed [CB-1:0]    i_by,
    input  wire logic signed [CB-1:0]    i_cx,
    input  wire logic signed [CB-1:0]    i_cy,
    input  wire logic signed [CB-1:0]    i_dx,
    input  wire logic signed [CB-1:0]    i_dy,
    output spc_pkg::t_side               o_s1,
    output spc_pkg::t_side               o_s2,
    output spc_pkg::t_side               o_t1,
    output spc_pkg::t_side               o_t2
);

    import spc_pkg::*;

    localparam int DW = CB + 1;
    localparam int PW = 2 * DW;

    logic signed [CB-1:0] w_e0x, w_e0y, w_e1x, w_e1y, w_px, w_py;
    logic signed [DW-1:0] w_opa, w_opb;
    logic signed [PW-1:0] w_prod;
    logic signed [PW:0]   w_cross;
    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] r_hold;
    logic                 r_deg;
    logic                 r_peq;
    t_side                w_side;
    t_side                r_side [4];

    always_comb begin
        case (i_ctrl.mul_step[2:1])
            2'd0: begin
                w_e0x = i_ax; w_e0y = i_ay; w_e1x = i_bx; w_e1y = i_by;
                w_px  = i_cx; w_py  = i_cy;
            end
            2'd1: begin
                w_e0x = i_ax; w_e0y = i_ay; w_e1x = i_bx; w_e1y = i_by;
                w_px  = i_dx; w_py  = i_dy;
            end
            2'd2: begin
                w_e0x = i_cx; w_e0y = i_cy; w_e1x = i_dx; w_e1y = i_dy;
                w_px  = i_ax; w_py  = i_ay;
            end
            default: begin
                w_e0x = i_cx; w_e0y = i_cy; w_e1x = i_dx; w_e1y = i_dy;
                w_px  = i_bx; w_py  = i_by;
            end
        endcase
    end

    always_comb begin
        if (i_ctrl.mul_step[0] == 1'b0) begin
            w_opa = DW'(w_e1y) - DW'(w_e0y);
            w_opb = DW'(w_px) - DW'(w_e0x);
        end else begin
            w_opa = DW'(w_e1x) - DW'(w_e0x);
            w_opb = DW'(w_py) - DW'(w_e0y);
        end
    end

    assign w_prod  = w_opa * w_opb;
    assign w_cross = {r_hold[PW-1], r_hold} - {r_prod[PW-1], r_prod};

    always_comb begin
        if (r_deg) begin
            w_side = r_peq ? SIDE_ZERO : SIDE_POS;
        end else if (w_cross == '0) begin
            w_side = SIDE_ZERO;
        end else if (w_cross[PW]) begin
            w_side = SIDE_NEG;
        end else begin
            w_side = SIDE_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= w_prod;
            if (i_ctrl.mul_step[0] == 1'b0) begin
                r_deg <= (w_e0x == w_e1x) && (w_e0y == w_e1y);
                r_peq <= (w_px == w_e0x) && (w_py == w_e0y);
            end
        end
        if (i_ctrl.res_en) begin
            if (i_ctrl.res_step[0] == 1'b0) begin
                r_hold <= r_prod;
            end else begin
                r_side[i_ctrl.res_step[2:1]] <= w_side;
            end
        end
    end

    assign o_s1 = r_side[0];
    assign o_s2 = r_side[1];
    assign o_t1 = r_side[2];
    assign o_t2 = r_side[3];

endmodule

`default_nettype wire

/* design/simple_polygon_check.sv */
// ----------------------------------------------------------------------------
// Simple polygon check
// Loads a closed polygon boundary and tests all non-adjacent edge pairs for
// intersection.
// ----------------------------------------------------------------------------
// Vertices arrive on i_vertex, one transfer per cycle while the block loads.
// The closing vertex repeats the first one and has last_vertex set. Only that
// transfer produces a result on o_result: is_simple, and overflow when more
// than MAX_VERTICES vertices came in (is_simple is then 0).
// After the closing vertex, ready stays low while the edge pairs are checked
// with one shared multiplier that needs eight products per pair. The first
// pair of each outer edge reads four vertices, each further pair one new
// vertex, and the check stops at the first intersecting pair. With fewer
// than five stored vertices, or on overflow, the result is shown in the
// cycle after the closing transfer.
// The result is held until the receiver takes it; no vertex is accepted
// meanwhile. Reset returns the block to loading an empty polygon; the store
// needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module simple_polygon_check #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    spc_vertex_if.sink       i_vertex,
    spc_result_if.source     o_result
);

    import spc_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int CB = COORD_BITS;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count;
    logic                  r_ovf;
    logic [CW-1:0]         r_n;
    logic [AW-1:0]         r_k;
    logic [AW-1:0]         r_j;
    logic [3:0]            r_step;
    logic                  r_res_simple;
    logic                  r_res_ovf;
    logic signed [CB-1:0]  r_ax, r_ay, r_bx, r_by, r_cx, r_cy, r_dx, r_dy;

    logic                  w_in_xfer;
    logic                  w_out_xfer;
    logic                  w_full;
    logic [CW-1:0]         w_n_final;
    logic                  w_ovf_final;
    logic                  w_wr_en;
    logic signed [CB-1:0]  w_in_x, w_in_y;
    logic [AW-1:0]         w_rd_addr;
    logic [2*CB-1:0]       w_rd_data;
    logic signed [CB-1:0]  w_rd_x, w_rd_y;
    t_side_ctrl            w_ctrl;
    t_side                 w_s1, w_s2, w_t1, w_t2;
    logic                  w_p1_zero, w_p1_neg, w_p2_zero, w_p2_neg;
    logic signed [CB-1:0]  w_e0x, w_e0y, w_e1x, w_e1y, w_px, w_py;
    logic                  w_box;
    logic                  w_meet;
    logic [CW-1:0]         w_limit;
    logic                  w_more_j;
    logic                  w_more_k;

    assign w_in_xfer   = i_vertex.valid && i_vertex.ready;
    assign w_out_xfer  = o_result.valid && o_result.ready;
    assign w_full      = (r_count == CW'(MAX_VERTICES));
    assign w_n_final   = w_full ? r_count : r_count + CW'(1);
    assign w_ovf_final = r_ovf || w_full;
    assign w_wr_en     = w_in_xfer && !w_full;
    assign w_in_x      = CB'(i_vertex.vertex_x);
    assign w_in_y      = CB'(i_vertex.vertex_y);

    spc_vertex_mem #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (2 * CB)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data ({w_in_x, w_in_y}),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_x = w_rd_data[2*CB-1:CB];
    assign w_rd_y = w_rd_data[CB-1:0];

    spc_side_unit #(
        .CB (CB)
    ) u_side (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_ax   (r_ax),
        .i_ay   (r_ay),
        .i_bx   (r_bx),
        .i_by   (r_by),
        .i_cx   (r_cx),
        .i_cy   (r_cy),
        .i_dx   (r_dx),
        .i_dy   (r_dy),
        .o_s1   (w_s1),
        .o_s2   (w_s2),
        .o_t1   (w_t1),
        .o_t2   (w_t2)
    );

    // Pair decision: a proper crossing, or a touching endpoint inside the
    // bounding range of the other edge.
    assign w_p1_zero = (w_s1 == SIDE_ZERO) || (w_s2 == SIDE_ZERO);
    assign w_p1_neg  = ((w_s1 == SIDE_POS) && (w_s2 == SIDE_NEG)) ||
                       ((w_s1 == SIDE_NEG) && (w_s2 == SIDE_POS));
    assign w_p2_zero = (w_t1 == SIDE_ZERO) || (w_t2 == SIDE_ZERO);
    assign w_p2_neg  = ((w_t1 == SIDE_POS) && (w_t2 == SIDE_NEG)) ||
                       ((w_t1 == SIDE_NEG) && (w_t2 == SIDE_POS));

    always_comb begin
        if (w_p1_zero) begin
            w_e0x = r_ax; w_e0y = r_ay; w_e1x = r_bx; w_e1y = r_by;
            w_px  = (w_s1 == SIDE_ZERO) ? r_cx : r_dx;
            w_py  = (w_s1 == SIDE_ZERO) ? r_cy : r_dy;
        end else begin
            w_e0x = r_cx; w_e0y = r_cy; w_e1x = r_dx; w_e1y = r_dy;
            w_px  = (w_t1 == SIDE_ZERO) ? r_ax : r_bx;
            w_py  = (w_t1 == SIDE_ZERO) ? r_ay : r_by;
        end
    end

    assign w_box = (((w_e0x <= w_px) && (w_px <= w_e1x)) ||
                    ((w_e1x <= w_px) && (w_px <= w_e0x))) &&
                   (((w_e0y <= w_py) && (w_py <= w_e1y)) ||
                    ((w_e1y <= w_py) && (w_py <= w_e0y)));
    assign w_meet = (w_p1_neg && w_p2_neg) || ((w_p1_zero || w_p2_zero) && w_box);

    assign w_limit  = (r_k == '0) ? r_n - CW'(2) : r_n - CW'(1);
    assign w_more_j = (CW'(r_j) + CW'(1)) < w_limit;
    assign w_more_k = ((CW + 1)'(r_k) + (CW + 1)'(4)) < (CW + 1)'(r_n);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_in_xfer && i_vertex.last_vertex) begin
                    if (w_ovf_final || (w_n_final < CW'(MIN_CHECK_VERTICES))) begin
                        n_state = ST_RESULT;
                    end else begin
                        n_state = ST_RD_A;
                    end
                end
            end
            ST_RD_A:    n_state = ST_RD_B;
            ST_RD_B:    n_state = ST_RD_C;
            ST_RD_C:    n_state = ST_RD_D;
            ST_RD_D:    n_state = ST_CAP_D;
            ST_RD_NEXT: n_state = ST_CAP_D;
            ST_CAP_D:   n_state = ST_MUL;
            ST_MUL: begin
                if (r_step == 4'(MUL_STEPS)) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (w_meet) begin
                    n_state = ST_RESULT;
                end else if (w_more_j) begin
                    n_state = ST_RD_NEXT;
                end else if (w_more_k) begin
                    n_state = ST_RD_A;
                end else begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (w_out_xfer) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        i_vertex.ready  = (r_state == ST_LOAD);
        o_result.valid  = (r_state == ST_RESULT);
        w_ctrl          = '0;
        case (r_state)
            ST_RD_A:    w_rd_addr = r_k;
            ST_RD_B:    w_rd_addr = r_k + AW'(1);
            ST_RD_C:    w_rd_addr = r_j;
            ST_RD_D:    w_rd_addr = r_j + AW'(1);
            ST_RD_NEXT: w_rd_addr = r_j + AW'(1);
            default:    w_rd_addr = r_j;
        endcase
        if (r_state == ST_MUL) begin
            w_ctrl.mul_en   = (r_step < 4'(MUL_STEPS));
            w_ctrl.mul_step = r_step[2:0];
            w_ctrl.res_en   = (r_step != '0);
            w_ctrl.res_step = 3'(r_step - 4'(1));
        end
    end

    assign o_result.is_simple = r_res_simple;
    assign o_result.overflow  = r_res_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_xfer) begin
                if (i_vertex.last_vertex) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_count <= w_n_final;
                    r_ovf   <= w_ovf_final;
                end
            end
            if (r_state == ST_MUL) begin
                r_step <= r_step + 4'(1);
            end else begin
                r_step <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_LOAD: begin
                r_n          <= w_n_final;
                r_k          <= '0;
                r_j          <= AW'(2);
                r_res_simple <= !w_ovf_final;
                r_res_ovf    <= w_ovf_final;
            end
            ST_RD_B: begin
                r_ax <= w_rd_x;
                r_ay <= w_rd_y;
            end
            ST_RD_C: begin
                r_bx <= w_rd_x;
                r_by <= w_rd_y;
            end
            ST_RD_D: begin
                r_cx <= w_rd_x;
                r_cy <= w_rd_y;
            end
            ST_RD_NEXT: begin
                r_cx <= r_dx;
                r_cy <= r_dy;
            end
            ST_CAP_D: begin
                r_dx <= w_rd_x;
                r_dy <= w_rd_y;
            end
            ST_EVAL: begin
                if (w_meet) begin
                    r_res_simple <= 1'b0;
                end else if (w_more_j) begin
                    r_j <= r_j + AW'(1);
                end else if (w_more_k) begin
                    r_k <= r_k + AW'(1);
                    r_j <= r_k + AW'(3);
                end
            end
            default: begin
                r_n <= r_n;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/spc_checker.sv */
// ----------------------------------------------------------------------------
// Simple polygon check port checker
// Concurrent checks on the ports of the checker block, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_in_last,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_is_simple,
    input wire logic i_overflow
);

    // An overflowed polygon is never reported as simple.
    a_ovf_not_simple: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_overflow |-> !i_is_simple)
        else $error("overflow result reported as simple");

    // No vertex is taken while a result waits.
    a_no_load_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("vertex input ready while a result is pending");

    // After a result transfer the block loads again.
    a_ready_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |=> i_in_ready)
        else $error("block not ready after result transfer");

    // A vertex that does not close the polygon gives no result.
    a_no_result_mid_polygon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_last |=> !i_out_valid)
        else $error("result after a vertex that does not close the polygon");

endmodule

bind simple_polygon_check spc_checker u_spc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vertex.valid),
    .i_in_ready  (i_vertex.ready),
    .i_in_last   (i_vertex.last_vertex),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_is_simple (o_result.is_simple),
    .i_overflow  (o_result.overflow)
);

`default_nettype wire

/* test/simple_polygon_check_tb.sv */
// ----------------------------------------------------------------------------
// Simple polygon check testbench
// Sends closed polygon outlines one vertex per transfer and checks every
// verdict against an edge-pair predictor or a pinned value. A short table of
// hand-picked outlines comes first, then random ones: monotone simple shapes,
// some with two vertices swapped, small-grid scatters full of touching and
// collinear edges, full-range scatters, store-filling and overflowing
// outlines, and a few broken closings. Both channels stall at random in two
// of three phases, with one long result stall and one full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module simple_polygon_check_tb;

    localparam int MAX_VTX       = 64;
    localparam int COORD_W       = 16;
    localparam int IN_W          = spc_pkg::IN_COORD_BITS;
    localparam int ITEM_TARGET   = 1000;
    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int DRAIN_CYCLES  = 50;
    localparam int HOLD_CYCLES   = 300;
    localparam int DIRECTED_ROWS = 22;

    typedef struct packed {
        logic is_simple;
        logic overflow;
    } t_verdict;

    typedef struct {
        int x;
        int y;
        bit last;
        bit pinned;
        bit exp_simple;
        bit exp_overflow;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    spc_vertex_if vertex_ch ();
    spc_result_if result_ch ();

    simple_polygon_check #(
        .MAX_VERTICES (MAX_VTX),
        .COORD_BITS   (COORD_W)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vertex (vertex_ch),
        .o_result (result_ch)
    );

    t_verdict verdict_q[$];
    int       held_x [MAX_VTX];
    int       held_y [MAX_VTX];
    int       held_count;
    bit       held_overflow;
    int       outline_x[$];
    int       outline_y[$];
    int       items_sent;
    int       verdicts_checked;
    int       fail_count;
    int       src_idle_pct;
    int       sink_idle_pct;
    int       cycle_count;

    t_row directed_rows [DIRECTED_ROWS] = '{
        '{-32768, -32768, 1'b1, 1'b1, 1'b1, 1'b0},
        '{ 32767,  32767, 1'b1, 1'b1, 1'b1, 1'b0},
        '{-32768, -32768, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ 32767, -32768, 1'b0, 1'b0, 1'b0, 1'b0},
        '{     0,  32767, 1'b0, 1'b0, 1'b0, 1'b0},
        '{-32768, -32768, 1'b1, 1'b1, 1'b1, 1'b0},
        '{-32768, -32768, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ 32767, -32768, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ 32767,  32767, 1'b0, 1'b0, 1'b0, 1'b0},
        '{-32768,  32767, 1'b0, 1'b0, 1'b0, 1'b0},
        '{-32768, -32768, 1'b1, 1'b0, 1'b0, 1'b0},
        '{-32768, -32768, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ 32767,  32767, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ 32767, -32768, 1'b0, 1'b0, 1'b0, 1'b0},
        '{-32768,  32767, 1'b0, 1'b0, 1'b0, 1'b0},
        '{-32768, -32768, 1'b1, 1'b0, 1'b0, 1'b0},
        '{     0,      0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{    10,      0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{    10,      0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{    10,     10, 1'b0, 1'b0, 1'b0, 1'b0},
        '{     0,     10, 1'b0, 1'b0, 1'b0, 1'b0},
        '{     0,      0, 1'b1, 1'b0, 1'b0, 1'b0}
    };

    function automatic int pick(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int side_sign(input int ax, ay, bx, by, px, py);
        longint cr;
        if (ax == bx && ay == by) begin
            return (px == ax && py == ay) ? 0 : 1;
        end
        cr = (longint'(by) - ay) * (longint'(px) - ax)
           - (longint'(bx) - ax) * (longint'(py) - ay);
        return (cr > 0) ? 1 : ((cr < 0) ? -1 : 0);
    endfunction

    function automatic bit in_box(input int ax, ay, bx, by, px, py);
        return px >= ((ax < bx) ? ax : bx) && px <= ((ax < bx) ? bx : ax)
            && py >= ((ay < by) ? ay : by) && py <= ((ay < by) ? by : ay);
    endfunction

    function automatic bit pair_meets(input int k, input int j);
        int ax, ay, bx, by, cx, cy, dx, dy, s1, s2, t1, t2;
        ax = held_x[k];
        ay = held_y[k];
        bx = held_x[k + 1];
        by = held_y[k + 1];
        cx = held_x[j];
        cy = held_y[j];
        dx = held_x[j + 1];
        dy = held_y[j + 1];
        s1 = side_sign(ax, ay, bx, by, cx, cy);
        s2 = side_sign(ax, ay, bx, by, dx, dy);
        t1 = side_sign(cx, cy, dx, dy, ax, ay);
        t2 = side_sign(cx, cy, dx, dy, bx, by);
        if (s1 * s2 < 0 && t1 * t2 < 0) begin
            return 1'b1;
        end
        if (s1 * s2 == 0) begin
            return (s1 == 0) ? in_box(ax, ay, bx, by, cx, cy) : in_box(ax, ay, bx, by, dx, dy);
        end
        if (t1 * t2 == 0) begin
            return (t1 == 0) ? in_box(cx, cy, dx, dy, ax, ay) : in_box(cx, cy, dx, dy, bx, by);
        end
        return 1'b0;
    endfunction

    function automatic bit outline_is_simple(input int n);
        int last_j;
        if (n < 4) begin
            return 1'b1;
        end
        for (int k = 0; k + 2 < n; k++) begin
            last_j = (k == 0) ? n - 2 : n - 1;
            for (int j = k + 2; j < last_j; j++) begin
                if (pair_meets(k, j)) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic void absorb_vertex(input int x, input int y, input logic last,
                                          input bit pinned, input t_verdict pinned_v);
        t_verdict v;
        if (held_count < MAX_VTX) begin
            held_x[held_count] = x;
            held_y[held_count] = y;
            held_count++;
        end else begin
            held_overflow = 1'b1;
        end
        if (last) begin
            if (pinned) begin
                v = pinned_v;
            end else if (held_overflow) begin
                v = '{is_simple: 1'b0, overflow: 1'b1};
            end else begin
                v = '{is_simple: outline_is_simple(held_count), overflow: 1'b0};
            end
            verdict_q.push_back(v);
            held_count    = 0;
            held_overflow = 1'b0;
        end
    endfunction

    function automatic void plan_polygon(input int idx);
        int n, shape, r, u, l, st, x0, oy, h, cx, xr, span, start, a, b, tmp, k;
        bit flip, rev, clean;
        int px[$], py[$];
        outline_x.delete();
        outline_y.delete();
        clean = 1'b0;
        shape = $urandom_range(0, 9);
        if (idx == 30 || idx == 75) begin
            n     = MAX_VTX - 1;
            shape = 0;
            clean = 1'b1;
        end else if (idx == 50 || $urandom_range(0, 99) < 3) begin
            n     = MAX_VTX + pick(0, 6);
            shape = 8;
        end else if (shape == 9) begin
            n = pick(0, 2);
        end else begin
            n = ($urandom_range(0, 99) < 10) ? pick(10, 24) : pick(3, 9);
        end
        if (shape <= 4) begin
            u  = pick(1, n - 2);
            l  = n - 2 - u;
            st = pick(1, 60000 / (n + 1));
            x0 = pick(-32768, 32767 - st * (n + 1));
            h  = pick(1, 16000);
            oy = pick(-32767 + h, 32767 - h);
            px.push_back(x0);
            py.push_back(oy);
            cx = x0;
            for (int i = 0; i < u; i++) begin
                cx += pick(1, st);
                px.push_back(cx);
                py.push_back(oy + pick(1, h));
            end
            xr = cx + pick(1, st);
            if (xr - x0 < l + 1) begin
                xr = x0 + l + 1;
            end
            px.push_back(xr);
            py.push_back(oy);
            span = xr - x0;
            for (int i = 0; i < l; i++) begin
                px.push_back(x0 + span * (l - i) / (l + 1));
                py.push_back(oy - pick(1, h));
            end
            if (!clean && $urandom_range(0, 9) < 3) begin
                a     = pick(0, n - 1);
                b     = pick(0, n - 1);
                tmp   = px[a];
                px[a] = px[b];
                px[b] = tmp;
                tmp   = py[a];
                py[a] = py[b];
                py[b] = tmp;
            end
        end else begin
            r = (shape == 8) ? 0 : pick(1, 4);
            repeat (n) begin
                px.push_back((r == 0) ? pick(-32768, 32767) : pick(-r, r));
                py.push_back((r == 0) ? pick(-32768, 32767) : pick(-r, r));
            end
        end
        flip  = $urandom_range(0, 1);
        rev   = $urandom_range(0, 1);
        start = (n > 0) ? pick(0, n - 1) : 0;
        for (int i = 0; i < n; i++) begin
            k = rev ? (start - i + n) % n : (start + i) % n;
            outline_x.push_back(flip ? py[k] : px[k]);
            outline_y.push_back(flip ? px[k] : py[k]);
        end
        if (n > 0 && (clean || $urandom_range(0, 9) != 0)) begin
            outline_x.push_back(outline_x[0]);
            outline_y.push_back(outline_y[0]);
        end else begin
            outline_x.push_back(pick(-32768, 32767));
            outline_y.push_back(pick(-32768, 32767));
        end
    endfunction

    task automatic send_vertex(input logic signed [IN_W-1:0] x,
                               input logic signed [IN_W-1:0] y,
                               input logic last, input bit pinned, input t_verdict pinned_v);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            vertex_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        vertex_ch.valid       <= 1'b1;
        vertex_ch.vertex_x    <= x;
        vertex_ch.vertex_y    <= y;
        vertex_ch.last_vertex <= last;
        @(posedge i_clk);
        while (!vertex_ch.ready) begin
            @(posedge i_clk);
        end
        absorb_vertex(int'($signed(x[COORD_W-1:0])), int'($signed(y[COORD_W-1:0])),
                      last, pinned, pinned_v);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drive_outline();
        for (int i = 0; i < outline_x.size(); i++) begin
            send_vertex(outline_x[i], outline_y[i], i == outline_x.size() - 1, 1'b0, '0);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $error("timed out after %0d cycles", cycle_count);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        result_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && verdicts_checked >= 8 && result_ch.valid) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (verdict_q.size() == 0) begin
                $error("unexpected result: is_simple %0b, overflow %0b",
                       result_ch.is_simple, result_ch.overflow);
                fail_count++;
            end else begin
                want = verdict_q.pop_front();
                if (result_ch.is_simple !== want.is_simple) begin
                    $error("is_simple: expected %0b, actual %0b",
                           want.is_simple, result_ch.is_simple);
                    fail_count++;
                end
                if (result_ch.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, actual %0b",
                           want.overflow, result_ch.overflow);
                    fail_count++;
                end
            end
            verdicts_checked++;
        end
    end

    initial begin : stimulus
        int polygon_idx;
        t_row row;
        items_sent            = 0;
        verdicts_checked      = 0;
        fail_count            = 0;
        held_count            = 0;
        held_overflow         = 1'b0;
        src_idle_pct          = 11;
        sink_idle_pct         = 68;
        polygon_idx           = 0;
        i_rst_n               <= 1'b0;
        vertex_ch.valid       <= 1'b0;
        vertex_ch.vertex_x    <= '0;
        vertex_ch.vertex_y    <= '0;
        vertex_ch.last_vertex <= 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = directed_rows[i];
            send_vertex(row.x, row.y, row.last, row.pinned,
                        '{is_simple: row.exp_simple, overflow: row.exp_overflow});
        end

        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= 2 * ITEM_TARGET / 3) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else if (items_sent >= ITEM_TARGET / 3) begin
                src_idle_pct  = 68;
                sink_idle_pct = 11;
            end
            plan_polygon(polygon_idx);
            drive_outline();
            if (polygon_idx == 60) begin
                vertex_ch.valid <= 1'b0;
                @(negedge i_clk);
                while (verdict_q.size() != 0) begin
                    @(negedge i_clk);
                end
            end
            polygon_idx++;
        end

        vertex_ch.valid <= 1'b0;
        while (verdict_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
